// ----- rtl/core/ldf_pkg.sv -----
// shared types and constants for the led dimmer with fade and display timeout
package ldf_pkg;

  localparam int unsigned MUL_W  = 24;
  localparam int unsigned PROD_W = 2 * MUL_W;

  typedef enum logic [2:0] {
    CFG_START_LEVEL   = 3'd0,
    CFG_STEP_SIZE     = 3'd1,
    CFG_IDLE_TIMEOUT  = 3'd2,
    CFG_FADE_INTERVAL = 3'd3,
    CFG_FULL_LUMENS   = 3'd4
  } cfg_idx_t;

  localparam logic [7:0]  START_LEVEL_RST   = 8'd0;
  localparam logic [7:0]  STEP_SIZE_RST     = 8'd15;
  localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd5000;
  localparam logic [7:0]  FADE_INTERVAL_RST = 8'd5;
  localparam logic [15:0] FULL_LUMENS_RST   = 16'd1000;

  // round-up reciprocals, exact over the operand ranges used here
  localparam logic [MUL_W-1:0] RECIP_255 = 24'd65794;    // shift 24
  localparam logic [MUL_W-1:0] RECIP_100 = 24'd10737419; // shift 30
  localparam logic [MUL_W-1:0] RECIP_BAT = 24'd3729181;  // 1/36855, shift 37

  localparam logic [MUL_W-1:0] PCT_SCALE = 24'd100;
  localparam logic [MUL_W-1:0] BAR_SCALE = 24'd126;
  localparam logic [MUL_W-1:0] BAT_SCALE = 24'd6600;
  localparam logic [MUL_W-1:0] UNITY     = 24'd1;
  localparam logic [24:0]      BAT_OFFSET = 25'd13513500;
  localparam logic [11:0]      BAT_LO    = 12'd2047;
  localparam logic [11:0]      BAT_HI    = 12'd2607;
  localparam logic [6:0]       PCT_FULL  = 7'd100;

  typedef struct packed {
    logic [7:0]  start_level;
    logic [7:0]  step_size;
    logic [15:0] idle_timeout;
    logic [7:0]  fade_interval;
    logic [15:0] full_lumens;
  } cfg_t;

  typedef struct packed {
    logic [7:0] drive_level;
    logic [7:0] goal_level;
    logic       display_on;
  } lvl_t;

  typedef struct packed {
    logic upd;
    logic up;
    logic down;
  } tick_t;

  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

endpackage

// ----- rtl/core/led_dimmer_fade_timeout.sv -----
// top level of the led dimmer with fade, display timeout and battery gauge
//
//   port group  direction  transfer condition       carries
//   in_*        input      in_valid & in_ready      press events, battery sample
//   out_*       output     out_valid & out_ready    duty, target, gauges, screen flag
//   cfg_*       input      cfg_valid & cfg_ready    register index and write data
//
// each tick first passes through an update state that updates level, idle and
// fade state, then the states M0 to M8 drive the shared 24x24 multiplier to compute
// the percent, lumen, bar and battery figures, one product per cycle
// a result waiting in the output register holds off only the final load
// reset is synchronous; no clearing pass, the block is ready right after reset
module led_dimmer_fade_timeout (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_up_press,
  input  logic        in_down_press,
  input  logic [11:0] in_battery_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pwm_duty,
  output logic [7:0]  out_target_level,
  output logic [6:0]  out_level_percent,
  output logic [15:0] out_lumen_estimate,
  output logic [6:0]  out_bar_width,
  output logic [6:0]  out_battery_percent,
  output logic        out_screen_active,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ldf_pkg::cfg_t     cfg_r;
  ldf_pkg::lvl_t     lvl;
  ldf_pkg::tick_t    tick;
  ldf_pkg::mul_req_t req;
  logic [ldf_pkg::PROD_W-1:0] prod_r;
  logic cfg_we;
  logic load_start;

  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid & cfg_ready;
  assign load_start = cfg_we && (cfg_index == ldf_pkg::CFG_START_LEVEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_level   <= ldf_pkg::START_LEVEL_RST;
      cfg_r.step_size     <= ldf_pkg::STEP_SIZE_RST;
      cfg_r.idle_timeout  <= ldf_pkg::IDLE_TIMEOUT_RST;
      cfg_r.fade_interval <= ldf_pkg::FADE_INTERVAL_RST;
      cfg_r.full_lumens   <= ldf_pkg::FULL_LUMENS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ldf_pkg::CFG_START_LEVEL:   cfg_r.start_level   <= cfg_data[7:0];
        ldf_pkg::CFG_STEP_SIZE:     cfg_r.step_size     <= cfg_data[7:0];
        ldf_pkg::CFG_IDLE_TIMEOUT:  cfg_r.idle_timeout  <= cfg_data;
        ldf_pkg::CFG_FADE_INTERVAL: cfg_r.fade_interval <= cfg_data[7:0];
        ldf_pkg::CFG_FULL_LUMENS:   cfg_r.full_lumens   <= cfg_data;
        default: ;
      endcase
    end
  end

  ldf_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .load_start (load_start),
    .load_value (cfg_data[7:0]),
    .tick       (tick),
    .lvl        (lvl)
  );

  ldf_mul u_mul (
    .clk    (clk),
    .req    (req),
    .prod_r (prod_r)
  );

  ldf_seq u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_up_press         (in_up_press),
    .in_down_press       (in_down_press),
    .in_battery_sample   (in_battery_sample),
    .cfg                 (cfg_r),
    .lvl                 (lvl),
    .tick                (tick),
    .req                 (req),
    .prod_r              (prod_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pwm_duty        (out_pwm_duty),
    .out_target_level    (out_target_level),
    .out_level_percent   (out_level_percent),
    .out_lumen_estimate  (out_lumen_estimate),
    .out_bar_width       (out_bar_width),
    .out_battery_percent (out_battery_percent),
    .out_screen_active   (out_screen_active)
  );

  // drive level moves by at most one count per update
  a_drive_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(load_start)) |->
      (lvl.drive_level == $past(lvl.drive_level) ||
       lvl.drive_level == $past(lvl.drive_level) + 8'd1 ||
       lvl.drive_level == $past(lvl.drive_level) - 8'd1))
    else $error("drive level jumped");

  // presses while the display is dark leave the target alone
  a_dark_goal: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(load_start) && !$past(lvl.display_on)) |->
      (lvl.goal_level == $past(lvl.goal_level)))
    else $error("target changed while display off");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_battery_percent <= 7'd100 && out_level_percent <= 7'd100 &&
       out_bar_width <= 7'd126))
    else $error("gauge output out of range");

endmodule

// ----- rtl/core/ldf_state.sv -----
// level, target, idle and fade state updated once per tick
module ldf_state (
  input  logic          clk,
  input  logic          rst_n,
  input  ldf_pkg::cfg_t cfg,
  input  logic          load_start,
  input  logic [7:0]    load_value,
  input  ldf_pkg::tick_t tick,
  output ldf_pkg::lvl_t lvl
);

  logic [7:0]  drive_r, drive_nxt;
  logic [7:0]  goal_r, goal_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        disp_r, disp_nxt;
  logic [7:0]  fade_r, fade_nxt;

  logic [8:0]  sum_up;
  logic [7:0]  goal_a;
  logic        press;
  logic [7:0]  fade_inc;
  logic        fade_step;

  always_comb begin
    sum_up = {1'b0, goal_r} + {1'b0, cfg.step_size};
    goal_a = goal_r;
    if (tick.up && disp_r) begin
      goal_a = sum_up[8] ? 8'hFF : sum_up[7:0];
    end
    goal_nxt = goal_a;
    if (tick.down && disp_r) begin
      goal_nxt = (goal_a >= cfg.step_size) ? goal_a - cfg.step_size : 8'd0;
    end

    press = tick.up | tick.down;
    if (press) begin
      idle_nxt = 16'd0;
    end else if (idle_r != 16'hFFFF) begin
      idle_nxt = idle_r + 16'd1;
    end else begin
      idle_nxt = idle_r;
    end
    disp_nxt = (press | disp_r) & ~(idle_nxt > cfg.idle_timeout);

    fade_inc  = (fade_r != 8'hFF) ? fade_r + 8'd1 : fade_r;
    fade_step = fade_inc >= cfg.fade_interval;
    fade_nxt  = fade_step ? 8'd0 : fade_inc;
    drive_nxt = drive_r;
    if (fade_step) begin
      if (drive_r < goal_nxt) begin
        drive_nxt = drive_r + 8'd1;
      end else if (drive_r > goal_nxt) begin
        drive_nxt = drive_r - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= ldf_pkg::START_LEVEL_RST;
      goal_r  <= ldf_pkg::START_LEVEL_RST;
      idle_r  <= 16'd0;
      disp_r  <= 1'b1;
      fade_r  <= 8'd0;
    end else if (load_start) begin
      drive_r <= load_value;
      goal_r  <= load_value;
    end else if (tick.upd) begin
      drive_r <= drive_nxt;
      goal_r  <= goal_nxt;
      idle_r  <= idle_nxt;
      disp_r  <= disp_nxt;
      fade_r  <= fade_nxt;
    end
  end

  assign lvl.drive_level = drive_r;
  assign lvl.goal_level  = goal_r;
  assign lvl.display_on  = disp_r;

endmodule

// ----- rtl/core/ldf_mul.sv -----
// shared multiplier with registered product
module ldf_mul (
  input  logic                          clk,
  input  ldf_pkg::mul_req_t             req,
  output logic [ldf_pkg::PROD_W-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= {{ldf_pkg::MUL_W{1'b0}}, req.a} * {{ldf_pkg::MUL_W{1'b0}}, req.b};
    end
  end

endmodule

// ----- rtl/core/ldf_seq.sv -----
// sequencer driving the shared multiplier and holding the result register
module ldf_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_up_press,
  input  logic                       in_down_press,
  input  logic [11:0]                in_battery_sample,
  input  ldf_pkg::cfg_t              cfg,
  input  ldf_pkg::lvl_t              lvl,
  output ldf_pkg::tick_t             tick,
  output ldf_pkg::mul_req_t          req,
  input  logic [ldf_pkg::PROD_W-1:0] prod_r,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_pwm_duty,
  output logic [7:0]                 out_target_level,
  output logic [6:0]                 out_level_percent,
  output logic [15:0]                out_lumen_estimate,
  output logic [6:0]                 out_bar_width,
  output logic [6:0]                 out_battery_percent,
  output logic                       out_screen_active
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_UPD  = 12'b0000_0000_0010,
    ST_M0   = 12'b0000_0000_0100,
    ST_M1   = 12'b0000_0000_1000,
    ST_M2   = 12'b0000_0001_0000,
    ST_M3   = 12'b0000_0010_0000,
    ST_M4   = 12'b0000_0100_0000,
    ST_M5   = 12'b0000_1000_0000,
    ST_M6   = 12'b0001_0000_0000,
    ST_M7   = 12'b0010_0000_0000,
    ST_M8   = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } seq_state_t;

  seq_state_t  state_r, state_nxt;
  logic        up_r, down_r;
  logic [11:0] raw_r;
  logic [6:0]  pct_r;
  logic [15:0] lumen_r;
  logic [6:0]  bar_r;
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic [24:0] bat_diff;
  logic [6:0]  bat_pct;

  assign bat_diff = prod_r[24:0] - ldf_pkg::BAT_OFFSET;

  always_comb begin
    if (raw_r <= ldf_pkg::BAT_LO) begin
      bat_pct = 7'd0;
    end else if (raw_r >= ldf_pkg::BAT_HI) begin
      bat_pct = ldf_pkg::PCT_FULL;
    end else begin
      bat_pct = prod_r[43:37];
    end
  end

  always_comb begin
    state_nxt = state_r;
    req       = '0;
    tick.upd  = 1'b0;
    tick.up   = up_r;
    tick.down = down_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        tick.upd  = 1'b1;
        state_nxt = ST_M0;
      end
      ST_M0: begin
        req       = '{1'b1, ldf_pkg::MUL_W'(lvl.goal_level), ldf_pkg::PCT_SCALE};
        state_nxt = ST_M1;
      end
      ST_M1: begin
        req       = '{1'b1, ldf_pkg::MUL_W'(prod_r[14:0]), ldf_pkg::RECIP_255};
        state_nxt = ST_M2;
      end
      ST_M2: begin
        req       = '{1'b1, ldf_pkg::MUL_W'(prod_r[30:24]), ldf_pkg::MUL_W'(cfg.full_lumens)};
        state_nxt = ST_M3;
      end
      ST_M3: begin
        req       = '{1'b1, ldf_pkg::MUL_W'(prod_r[22:0]), ldf_pkg::RECIP_100};
        state_nxt = ST_M4;
      end
      ST_M4: begin
        req       = '{1'b1, ldf_pkg::MUL_W'(pct_r), ldf_pkg::BAR_SCALE};
        state_nxt = ST_M5;
      end
      ST_M5: begin
        req       = '{1'b1, ldf_pkg::MUL_W'(prod_r[13:0]), ldf_pkg::RECIP_100};
        state_nxt = ST_M6;
      end
      ST_M6: begin
        req       = '{1'b1, ldf_pkg::MUL_W'(raw_r), ldf_pkg::BAT_SCALE};
        state_nxt = ST_M7;
      end
      ST_M7: begin
        req       = '{1'b1, ldf_pkg::MUL_W'(bat_diff[21:0]), ldf_pkg::UNITY};
        state_nxt = ST_M8;
      end
      ST_M8: begin
        req       = '{1'b1, ldf_pkg::MUL_W'(prod_r[21:0]), ldf_pkg::RECIP_BAT};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // captured input and intermediate results
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      up_r   <= in_up_press;
      down_r <= in_down_press;
      raw_r  <= in_battery_sample;
    end
    if (state_r == ST_M2) begin
      pct_r <= prod_r[30:24];
    end
    if (state_r == ST_M4) begin
      lumen_r <= prod_r[45:30];
    end
    if (state_r == ST_M6) begin
      bar_r <= prod_r[36:30];
    end
    if (out_load) begin
      out_pwm_duty        <= lvl.drive_level;
      out_target_level    <= lvl.goal_level;
      out_level_percent   <= pct_r;
      out_lumen_estimate  <= lumen_r;
      out_bar_width       <= bar_r;
      out_battery_percent <= bat_pct;
      out_screen_active   <= lvl.display_on;
    end
  end

  assign out_valid = out_valid_r;

endmodule
